// File: sv/plrs_pkg.sv
package plrs_pkg;

  localparam int TRIG_BITS    = 26;
  localparam int CORDIC_STEPS = 30;
  localparam int DEN_W        = 58;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [40:0] HALF_PI_Q30     = 41'sd1686629713;
  localparam logic [26:0]        TRIG_ONE        = 27'd67108864;

  typedef enum logic [2:0] {
    REG_X_LOW   = 3'd0,
    REG_Y_LOW   = 3'd1,
    REG_X_HIGH  = 3'd2,
    REG_Y_HIGH  = 3'd3,
    REG_SPACING = 3'd4
  } plrs_reg_t;

  typedef enum logic [2:0] {
    F_IDLE, F_CORDIC, F_TRIG, F_MUL, F_SUM, F_DIV, F_DIVW, F_PUSH
  } plrs_front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_AY, B_AYW, B_AX, B_AXW, B_BX, B_BXW, B_BY, B_BYW, B_EMIT
  } plrs_back_state_t;

  // One sweep, handed from the front to the back.
  typedef struct packed {
    logic               none;
    logic               capped;
    logic               neg;
    logic [6:0]         count;
    logic [26:0]        cs;
    logic signed [27:0] sn;
    logic signed [63:0] a_p;   // sn * x_low
    logic signed [63:0] b_p;   // cs * start y
    logic signed [63:0] c_p;   // cs * far y
    logic signed [63:0] d_p;   // sn * x_high
    logic signed [63:0] k0;
    logic signed [63:0] step;
  } plrs_job_t;

  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] v;
    case (i)
      5'd0:  v = 31'h3243F6A8;
      5'd1:  v = 31'h1DAC6705;
      5'd2:  v = 31'h0FADBAFC;
      5'd3:  v = 31'h07F56EA6;
      5'd4:  v = 31'h03FEAB76;
      5'd5:  v = 31'h01FFD55B;
      5'd6:  v = 31'h00FFFAAA;
      5'd7:  v = 31'h007FFF55;
      5'd8:  v = 31'h003FFFEA;
      5'd9:  v = 31'h001FFFFD;
      5'd10: v = 31'h000FFFFF;
      5'd11: v = 31'h0007FFFF;
      5'd12: v = 31'h0003FFFF;
      5'd13: v = 31'h0001FFFF;
      5'd14: v = 31'h0000FFFF;
      5'd15: v = 31'h00007FFF;
      5'd16: v = 31'h00003FFF;
      5'd17: v = 31'h00001FFF;
      5'd18: v = 31'h00000FFF;
      5'd19: v = 31'h000007FF;
      5'd20: v = 31'h000003FF;
      5'd21: v = 31'h000001FF;
      5'd22: v = 31'h000000FF;
      5'd23: v = 31'h0000007F;
      5'd24: v = 31'h0000003F;
      5'd25: v = 31'h0000001F;
      5'd26: v = 31'h0000000F;
      5'd27: v = 31'h00000007;
      5'd28: v = 31'h00000003;
      5'd29: v = 31'h00000001;
      default: v = 31'h0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sign_sat(input logic signed [63:0] n);
    logic signed [31:0] r;
    if (n > 64'sd0) r = 32'sh7FFFFFFF;
    else if (n < 64'sd0) r = 32'sh80000000;
    else r = 32'sd0;
    return r;
  endfunction

endpackage

// File: sv/plrs_div.sv
module plrs_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [63:0]                  num,
  input  logic signed [plrs_pkg::DEN_W-1:0]   den,
  output logic                                done,
  output logic signed [65:0]                  quo
);

  localparam int DW = plrs_pkg::DEN_W;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic [64:0]   dvd_r, dvd_nxt;
  logic [DW-2:0] rem_r, rem_nxt;
  logic [DW-2:0] den_r, den_nxt;
  logic          neg_r, neg_nxt;

  logic [63:0]   mag_n;
  logic [DW-1:0] den_neg;
  logic [DW-2:0] mag_d;
  logic [DW-1:0] trial;
  logic [DW-1:0] diff;
  logic          qbit;

  always_comb begin
    mag_n   = num[63] ? (~num + 64'd1) : num;
    den_neg = ~den + {{(DW-1){1'b0}}, 1'b1};
    mag_d   = den[DW-1] ? den_neg[DW-2:0] : den[DW-2:0];
    trial   = {rem_r, dvd_r[64]};
    diff    = trial - {1'b0, den_r};
    qbit    = trial >= {1'b0, den_r};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      // round half away from zero: add half the divisor to the magnitude
      dvd_nxt  = {1'b0, mag_n} + {{(67-DW){1'b0}}, mag_d[DW-2:1]};
      den_nxt  = mag_d;
      rem_nxt  = '0;
      neg_nxt  = num[63] ^ den[DW-1];
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = qbit ? diff[DW-2:0] : trial[DW-2:0];
      dvd_nxt = {dvd_r[63:0], qbit};
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd64) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});

endmodule

// File: sv/plrs_fifo.sv
module plrs_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  plrs_pkg::plrs_job_t push_job,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output plrs_pkg::plrs_job_t head_job
);

  plrs_pkg::plrs_job_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] fill_r;

  assign full       = fill_r == 2'd2;
  assign head_valid = fill_r != 2'd0;
  assign head_job   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wp_r] <= push_job;
  end

endmodule

// File: sv/plrs_front.sv
module plrs_front #(
  parameter int MAX_LINES = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [17:0]  in_angle,
  input  logic signed [31:0]  x_low,
  input  logic signed [31:0]  y_low,
  input  logic signed [31:0]  x_high,
  input  logic signed [31:0]  y_high,
  input  logic [30:0]         line_spacing,
  output logic                push,
  output plrs_pkg::plrs_job_t push_job,
  input  logic                full
);

  plrs_pkg::plrs_front_state_t state_r, state_nxt;

  logic signed [32:0] z_r, z_nxt;
  logic signed [33:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [4:0]         it_r, it_nxt;
  logic               neg_r, neg_nxt;
  logic [26:0]        cs_r, cs_nxt, sa_r, sa_nxt;
  logic [2:0]         mi_r, mi_nxt;
  logic signed [63:0] p_r [6];
  logic signed [63:0] width_r, width_nxt, k0_r, k0_nxt;
  logic [6:0]         count_r, count_nxt;
  logic               capped_r, capped_nxt;

  logic signed [40:0] z_in;
  logic signed [40:0] z_sat;
  logic signed [33:0] sh_x, sh_y;
  logic signed [32:0] atan_s;
  logic signed [33:0] cx_rnd, cy_rnd;
  logic signed [27:0] sn;
  logic signed [33:0] op_a;
  logic signed [27:0] op_b;
  logic signed [61:0] prod;
  logic signed [32:0] dy, dx;
  logic [30:0]        spacing_eff;
  logic signed [63:0] step_mag, half_step;
  logic               div_start, div_done;
  logic signed [65:0] div_q;

  always_comb begin
    z_in   = $signed({{23{in_angle[17]}}, in_angle}) <<< (30 - FRAC_BITS);
    if (z_in > plrs_pkg::HALF_PI_Q30) z_sat = plrs_pkg::HALF_PI_Q30;
    else if (z_in < -plrs_pkg::HALF_PI_Q30) z_sat = -plrs_pkg::HALF_PI_Q30;
    else z_sat = z_in;
    sh_x   = cy_r >>> it_r;
    sh_y   = cx_r >>> it_r;
    atan_s = $signed({2'b00, plrs_pkg::atan_q30(it_r)});
    cx_rnd = (cx_r + 34'sd8) >>> (30 - plrs_pkg::TRIG_BITS);
    cy_rnd = (cy_r + 34'sd8) >>> (30 - plrs_pkg::TRIG_BITS);
    sn     = neg_r ? -$signed({1'b0, sa_r}) : $signed({1'b0, sa_r});
    dy     = $signed({y_high[31], y_high}) - $signed({y_low[31], y_low});
    dx     = $signed({x_high[31], x_high}) - $signed({x_low[31], x_low});
    spacing_eff = (line_spacing == 31'd0) ? 31'd1 : line_spacing;
    step_mag  = $signed({7'd0, spacing_eff, 26'd0});
    half_step = $signed({8'd0, spacing_eff, 25'd0});

    case (mi_r)
      3'd0: begin op_a = 34'(x_low); op_b = sn; end
      3'd1: begin op_a = 34'(neg_r ? y_low : y_high); op_b = $signed({1'b0, cs_r}); end
      3'd2: begin op_a = 34'(neg_r ? y_high : y_low); op_b = $signed({1'b0, cs_r}); end
      3'd3: begin op_a = 34'(x_high); op_b = sn; end
      3'd4: begin op_a = 34'(dy); op_b = $signed({1'b0, cs_r}); end
      3'd5: begin op_a = 34'(dx); op_b = $signed({1'b0, sa_r}); end
      default: begin op_a = '0; op_b = '0; end
    endcase
    prod = op_a * op_b;
  end

  always_comb begin
    state_nxt  = state_r;
    z_nxt      = z_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    it_nxt     = it_r;
    neg_nxt    = neg_r;
    cs_nxt     = cs_r;
    sa_nxt     = sa_r;
    mi_nxt     = mi_r;
    width_nxt  = width_r;
    k0_nxt     = k0_r;
    count_nxt  = count_r;
    capped_nxt = capped_r;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    push       = 1'b0;

    case (state_r)
      plrs_pkg::F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          neg_nxt   = z_sat < 41'sd0;
          z_nxt     = (z_sat < 41'sd0) ? -z_sat[32:0] : z_sat[32:0];
          cx_nxt    = plrs_pkg::CORDIC_GAIN_Q30;
          cy_nxt    = '0;
          it_nxt    = '0;
          state_nxt = plrs_pkg::F_CORDIC;
        end
      end
      plrs_pkg::F_CORDIC: begin
        if (z_r >= 33'sd0) begin
          cx_nxt = cx_r - sh_x;
          cy_nxt = cy_r + sh_y;
          z_nxt  = z_r - atan_s;
        end else begin
          cx_nxt = cx_r + sh_x;
          cy_nxt = cy_r - sh_y;
          z_nxt  = z_r + atan_s;
        end
        it_nxt = it_r + 5'd1;
        if (it_r == 5'(plrs_pkg::CORDIC_STEPS - 1)) state_nxt = plrs_pkg::F_TRIG;
      end
      plrs_pkg::F_TRIG: begin
        // round to Q.26 and clamp into [0, 1]
        if (cx_rnd < 34'sd0) cs_nxt = '0;
        else if (cx_rnd > $signed({7'd0, plrs_pkg::TRIG_ONE})) cs_nxt = plrs_pkg::TRIG_ONE;
        else cs_nxt = cx_rnd[26:0];
        if (cy_rnd < 34'sd0) sa_nxt = '0;
        else if (cy_rnd > $signed({7'd0, plrs_pkg::TRIG_ONE})) sa_nxt = plrs_pkg::TRIG_ONE;
        else sa_nxt = cy_rnd[26:0];
        mi_nxt    = '0;
        state_nxt = plrs_pkg::F_MUL;
      end
      plrs_pkg::F_MUL: begin
        mi_nxt = mi_r + 3'd1;
        if (mi_r == 3'd5) state_nxt = plrs_pkg::F_SUM;
      end
      plrs_pkg::F_SUM: begin
        width_nxt = p_r[4] + p_r[5];
        k0_nxt    = p_r[1] - p_r[0] + (neg_r ? half_step : -half_step);
        state_nxt = plrs_pkg::F_DIV;
      end
      plrs_pkg::F_DIV: begin
        capped_nxt = 1'b0;
        count_nxt  = '0;
        if (width_r > 64'sd0) begin
          div_start = 1'b1;
          state_nxt = plrs_pkg::F_DIVW;
        end else begin
          state_nxt = plrs_pkg::F_PUSH;
        end
      end
      plrs_pkg::F_DIVW: begin
        if (div_done) begin
          if (div_q > $signed(66'(MAX_LINES))) begin
            count_nxt  = 7'(MAX_LINES);
            capped_nxt = 1'b1;
          end else begin
            count_nxt = div_q[6:0];
          end
          state_nxt = plrs_pkg::F_PUSH;
        end
      end
      plrs_pkg::F_PUSH: begin
        if (!full) begin
          push      = 1'b1;
          state_nxt = plrs_pkg::F_IDLE;
        end
      end
      default: state_nxt = plrs_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    push_job.none   = count_r == 7'd0;
    push_job.capped = capped_r;
    push_job.neg    = neg_r;
    push_job.count  = count_r;
    push_job.cs     = cs_r;
    push_job.sn     = sn;
    push_job.a_p    = p_r[0];
    push_job.b_p    = p_r[1];
    push_job.c_p    = p_r[2];
    push_job.d_p    = p_r[3];
    push_job.k0     = k0_r;
    push_job.step   = neg_r ? step_mag : -step_mag;
  end

  plrs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (width_r),
    .den   (step_mag[plrs_pkg::DEN_W-1:0]),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plrs_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    z_r      <= z_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    it_r     <= it_nxt;
    neg_r    <= neg_nxt;
    cs_r     <= cs_nxt;
    sa_r     <= sa_nxt;
    mi_r     <= mi_nxt;
    width_r  <= width_nxt;
    k0_r     <= k0_nxt;
    count_r  <= count_nxt;
    capped_r <= capped_nxt;
    if (state_r == plrs_pkg::F_MUL && mi_r < 3'd6) p_r[mi_r] <= 64'(prod);
  end

endmodule

// File: sv/plrs_back.sv
module plrs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  plrs_pkg::plrs_job_t job,
  output logic                job_pop,
  input  logic signed [31:0]  x_low,
  input  logic signed [31:0]  y_low,
  input  logic signed [31:0]  x_high,
  input  logic signed [31:0]  y_high,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_start_x,
  output logic signed [31:0]  out_start_y,
  output logic signed [31:0]  out_end_x,
  output logic signed [31:0]  out_end_y,
  output logic [5:0]          out_line_index,
  output logic                out_last_line,
  output logic                out_no_lines,
  output logic                out_count_capped
);

  localparam int DW = plrs_pkg::DEN_W;

  plrs_pkg::plrs_back_state_t state_r, state_nxt;
  plrs_pkg::plrs_job_t        job_r, job_nxt;

  logic signed [63:0] k_r, k_nxt;
  logic [5:0]         line_r, line_nxt;
  logic signed [31:0] ax_r, ax_nxt, ay_r, ay_nxt, bx_r, bx_nxt, by_r, by_nxt;

  logic               ov_r, ov_nxt;
  logic signed [31:0] o_sx_r, o_sy_r, o_ex_r, o_ey_r;
  logic [5:0]         o_idx_r;
  logic               o_last_r, o_none_r, o_cap_r;
  logic               load, last;

  logic               div_start, div_done;
  logic signed [63:0] div_num;
  logic signed [DW-1:0] div_den;
  logic signed [65:0] div_q;

  logic signed [31:0] sy, fy;
  logic signed [DW-1:0] cs_d, sn_d;

  always_comb begin
    sy   = job_r.neg ? y_low : y_high;
    fy   = job_r.neg ? y_high : y_low;
    cs_d = $signed({{(DW-27){1'b0}}, job_r.cs});
    sn_d = DW'(job_r.sn);
    last = job_r.none || ({1'b0, line_r} == job_r.count - 7'd1);

    state_nxt = state_r;
    job_nxt   = job_r;
    k_nxt     = k_r;
    line_nxt  = line_r;
    ax_nxt    = ax_r;
    ay_nxt    = ay_r;
    bx_nxt    = bx_r;
    by_nxt    = by_r;
    job_pop   = 1'b0;
    div_start = 1'b0;
    div_num   = k_r + job_r.a_p;
    div_den   = cs_d;
    load      = 1'b0;

    case (state_r)
      plrs_pkg::B_IDLE: begin
        if (job_valid) begin
          job_pop  = 1'b1;
          job_nxt  = job;
          k_nxt    = job.k0;
          line_nxt = '0;
          ax_nxt   = '0;
          ay_nxt   = '0;
          bx_nxt   = '0;
          by_nxt   = '0;
          state_nxt = job.none ? plrs_pkg::B_EMIT : plrs_pkg::B_AY;
        end
      end
      plrs_pkg::B_AY: begin
        ax_nxt = x_low;
        by_nxt = sy;
        if (job_r.cs != 27'd0) begin
          div_start = 1'b1;
          state_nxt = plrs_pkg::B_AYW;
        end else begin
          state_nxt = plrs_pkg::B_AX;
        end
      end
      plrs_pkg::B_AYW: begin
        if (div_done) begin
          if (div_q >= 66'(y_low) && div_q <= 66'(y_high)) begin
            ay_nxt    = div_q[31:0];
            state_nxt = plrs_pkg::B_BX;
          end else begin
            state_nxt = plrs_pkg::B_AX;
          end
        end
      end
      plrs_pkg::B_AX: begin
        // start point off the low-x edge: sit on the far y edge instead
        ay_nxt  = fy;
        div_num = job_r.c_p - k_r;
        div_den = sn_d;
        if (job_r.sn == 28'sd0) begin
          ax_nxt    = plrs_pkg::sign_sat(div_num);
          state_nxt = plrs_pkg::B_BX;
        end else begin
          div_start = 1'b1;
          state_nxt = plrs_pkg::B_AXW;
        end
      end
      plrs_pkg::B_AXW: begin
        div_num = job_r.c_p - k_r;
        div_den = sn_d;
        if (div_done) begin
          ax_nxt    = plrs_pkg::sat32(div_q);
          state_nxt = plrs_pkg::B_BX;
        end
      end
      plrs_pkg::B_BX: begin
        div_num = job_r.b_p - k_r;
        div_den = sn_d;
        if (job_r.sn != 28'sd0) begin
          div_start = 1'b1;
          state_nxt = plrs_pkg::B_BXW;
        end else begin
          state_nxt = plrs_pkg::B_BY;
        end
      end
      plrs_pkg::B_BXW: begin
        div_num = job_r.b_p - k_r;
        div_den = sn_d;
        if (div_done) begin
          if (div_q >= 66'(x_low) && div_q <= 66'(x_high)) begin
            bx_nxt    = div_q[31:0];
            state_nxt = plrs_pkg::B_EMIT;
          end else begin
            state_nxt = plrs_pkg::B_BY;
          end
        end
      end
      plrs_pkg::B_BY: begin
        // end point off the start-y edge: sit on the high-x edge instead
        bx_nxt  = x_high;
        div_num = k_r + job_r.d_p;
        if (job_r.cs == 27'd0) begin
          by_nxt    = plrs_pkg::sign_sat(div_num);
          state_nxt = plrs_pkg::B_EMIT;
        end else begin
          div_start = 1'b1;
          state_nxt = plrs_pkg::B_BYW;
        end
      end
      plrs_pkg::B_BYW: begin
        div_num = k_r + job_r.d_p;
        if (div_done) begin
          by_nxt    = plrs_pkg::sat32(div_q);
          state_nxt = plrs_pkg::B_EMIT;
        end
      end
      plrs_pkg::B_EMIT: begin
        if (!ov_r || out_ready) begin
          load = 1'b1;
          if (last) begin
            state_nxt = plrs_pkg::B_IDLE;
          end else begin
            line_nxt  = line_r + 6'd1;
            k_nxt     = k_r + job_r.step;
            state_nxt = plrs_pkg::B_AY;
          end
        end
      end
      default: state_nxt = plrs_pkg::B_IDLE;
    endcase

    ov_nxt = load ? 1'b1 : (out_ready ? 1'b0 : ov_r);
  end

  plrs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plrs_pkg::B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    job_r  <= job_nxt;
    k_r    <= k_nxt;
    line_r <= line_nxt;
    ax_r   <= ax_nxt;
    ay_r   <= ay_nxt;
    bx_r   <= bx_nxt;
    by_r   <= by_nxt;
    if (load) begin
      o_sx_r   <= ax_r;
      o_sy_r   <= ay_r;
      o_ex_r   <= bx_r;
      o_ey_r   <= by_r;
      o_idx_r  <= line_r;
      o_last_r <= last;
      o_none_r <= job_r.none;
      o_cap_r  <= job_r.capped;
    end
  end

  assign out_valid        = ov_r;
  assign out_start_x      = o_sx_r;
  assign out_start_y      = o_sy_r;
  assign out_end_x        = o_ex_r;
  assign out_end_y        = o_ey_r;
  assign out_line_index   = o_idx_r;
  assign out_last_line    = o_last_r;
  assign out_no_lines     = o_none_r;
  assign out_count_capped = o_cap_r;

endmodule

// File: sv/parallel_line_rectangle_sweep.sv
// Channel   Direction  Handshake             Payload
// in        input      in_valid/in_ready     in_angle (Q1.16 rad)
// out       output     out_valid/out_ready   start/end x,y, line_index, flags
// cfg       input      cfg_wr_en             cfg_index, cfg_data
//
// Front: accept, CORDIC iterations, trig rounding, multiplies and sums, then a
// serial divide for the line count. Back: per line, two to four divides
// through one serial divider.
// Reset is synchronous and active low; it clears control state and loads
// the rectangle and spacing registers with their defaults.
// A two-entry job queue lets the front take the next angle while the back
// works; the output register frees the back while a result waits.
module parallel_line_rectangle_sweep #(
  parameter int MAX_LINES = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [17:0] in_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_start_x,
  output logic signed [31:0] out_start_y,
  output logic signed [31:0] out_end_x,
  output logic signed [31:0] out_end_y,
  output logic [5:0]         out_line_index,
  output logic               out_last_line,
  output logic               out_no_lines,
  output logic               out_count_capped,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // Rectangle and spacing registers.
  logic signed [31:0] x_low_r, y_low_r, x_high_r, y_high_r;
  logic [30:0]        spacing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_low_r   <= 32'sd0;
      y_low_r   <= 32'sd0;
      x_high_r  <= 32'sd655360;
      y_high_r  <= 32'sd655360;
      spacing_r <= 31'd6554;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        plrs_pkg::REG_X_LOW:   x_low_r   <= cfg_data;
        plrs_pkg::REG_Y_LOW:   y_low_r   <= cfg_data;
        plrs_pkg::REG_X_HIGH:  x_high_r  <= cfg_data;
        plrs_pkg::REG_Y_HIGH:  y_high_r  <= cfg_data;
        plrs_pkg::REG_SPACING: spacing_r <= cfg_data[30:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  plrs_pkg::plrs_job_t push_job, head_job;
  logic push, full, pop, head_valid;

  // Front: angle to trig, products, line count.
  plrs_front #(
    .MAX_LINES (MAX_LINES),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_angle     (in_angle),
    .x_low        (x_low_r),
    .y_low        (y_low_r),
    .x_high       (x_high_r),
    .y_high       (y_high_r),
    .line_spacing (spacing_r),
    .push         (push),
    .push_job     (push_job),
    .full         (full)
  );

  // Hold finished sweeps until the back is free.
  plrs_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Back: clip each line and emit one item per line, or one item for an empty sweep.
  plrs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_valid        (head_valid),
    .job              (head_job),
    .job_pop          (pop),
    .x_low            (x_low_r),
    .y_low            (y_low_r),
    .x_high           (x_high_r),
    .y_high           (y_high_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_start_x      (out_start_x),
    .out_start_y      (out_start_y),
    .out_end_x        (out_end_x),
    .out_end_y        (out_end_y),
    .out_line_index   (out_line_index),
    .out_last_line    (out_last_line),
    .out_no_lines     (out_no_lines),
    .out_count_capped (out_count_capped)
  );

endmodule

// File: verif/parallel_line_rectangle_sweep_checker.sv
module parallel_line_rectangle_sweep_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [17:0] in_angle,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_start_x,
  input  logic signed [31:0] out_start_y,
  input  logic signed [31:0] out_end_x,
  input  logic signed [31:0] out_end_y,
  input  logic [5:0]         out_line_index,
  input  logic               out_last_line,
  input  logic               out_no_lines,
  input  logic               out_count_capped,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 errors,
  output int                 pending,
  output int                 segments_seen
);

  localparam int  LINE_CAP  = 64;
  localparam int  TRIG_Q    = 26;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint GAIN    = 64'sd652032874;
  localparam longint TRIG_UNIT = 64'sd1 << TRIG_Q;

  typedef struct {
    logic signed [31:0] sx, sy, ex, ey;
    logic [5:0]         idx;
    logic               last, none, capped;
  } segment_t;

  const longint arctan_q30 [30] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
    'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
    'h0000003F, 'h0000001F, 'h0000000F, 'h00000007, 'h00000003, 'h00000001};

  longint   rect_xl, rect_yl, rect_xh, rect_yh, spacing;
  segment_t expected_segments[$];

  assign pending = expected_segments.size();

  function automatic longint round_div(longint n, longint d);
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Divide on the fallback edge; a zero divisor saturates by the numerator sign.
  function automatic longint edge_div(longint n, longint d);
    if (d == 0) return n > 0 ? 64'sd2147483647 : (n < 0 ? -64'sd2147483648 : 0);
    return clip32(round_div(n, d));
  endfunction

  function automatic longint trig_round(longint v);
    longint r;
    r = (v + (64'sd1 << 3)) >>> 4;
    if (r < 0) r = 0;
    if (r > TRIG_UNIT) r = TRIG_UNIT;
    return r;
  endfunction

  // Queue one predicted segment at the tail.
  task automatic add_expected(segment_t s);
    expected_segments.insert(expected_segments.size(), s);
  endtask

  task automatic predict_sweep(logic signed [17:0] ang);
    longint   z, cx, cy, tx, ty, cs, sa, sn, sx, sy, fy, step, width, count, k;
    longint   ax, ay, bx, by;
    bit       neg, capped, ok;
    segment_t s;
    z = longint'(ang) * 16384;
    if (z > HALF_PI) z = HALF_PI;
    if (z < -HALF_PI) z = -HALF_PI;
    neg = z < 0;
    if (neg) z = -z;
    cx = GAIN;
    cy = 0;
    for (int i = 0; i < 30; i++) begin
      tx = cy >>> i;
      ty = cx >>> i;
      if (z >= 0) begin
        cx -= tx; cy += ty; z -= arctan_q30[i];
      end else begin
        cx += tx; cy -= ty; z += arctan_q30[i];
      end
    end
    cs = trig_round(cx);
    sa = trig_round(cy);
    sn = neg ? -sa : sa;
    sx = rect_xl;
    sy = neg ? rect_yl : rect_yh;
    fy = neg ? rect_yh : rect_yl;
    step = (spacing != 0 ? spacing : 64'sd1) << TRIG_Q;
    width = (rect_yh - rect_yl) * cs + (rect_xh - rect_xl) * sa;
    count = width > 0 ? (width + step / 2) / step : 0;
    capped = count > LINE_CAP;
    if (capped) count = LINE_CAP;
    if (count == 0) begin
      s = '{sx: 0, sy: 0, ex: 0, ey: 0, idx: 0, last: 1, none: 1, capped: 0};
      add_expected(s);
      return;
    end
    if (!neg) step = -step;
    k = -sn * sx + cs * sy + step / 2;
    for (int i = 0; i < count; i++) begin
      ax = sx;
      by = sy;
      ok = cs != 0;
      if (ok) begin
        ay = round_div(k + sn * sx, cs);
        ok = ay >= rect_yl && ay <= rect_yh;
      end
      if (!ok) begin
        ay = fy;
        ax = edge_div(cs * fy - k, sn);
      end
      ok = sn != 0;
      if (ok) begin
        bx = round_div(cs * sy - k, sn);
        ok = bx >= rect_xl && bx <= rect_xh;
      end
      if (!ok) begin
        bx = rect_xh;
        by = edge_div(k + sn * rect_xh, cs);
      end
      s = '{sx: ax[31:0], sy: ay[31:0], ex: bx[31:0], ey: by[31:0], idx: i[5:0],
            last: i == count - 1, none: 0, capped: capped};
      add_expected(s);
      k += step;
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d (segment %0d)", what, got, want,
             segments_seen);
    errors++;
  endtask

  initial errors = 0;
  initial segments_seen = 0;

  always @(posedge clk) begin
    segment_t s;
    if (!rst_n) begin
      rect_xl = 0;
      rect_yl = 0;
      rect_xh = 655360;
      rect_yh = 655360;
      spacing = 6554;
      expected_segments.delete();
    end else begin
      if (cfg_wr_en) begin
        case (plrs_pkg::plrs_reg_t'(cfg_index))
          plrs_pkg::REG_X_LOW:   rect_xl = longint'($signed(cfg_data));
          plrs_pkg::REG_Y_LOW:   rect_yl = longint'($signed(cfg_data));
          plrs_pkg::REG_X_HIGH:  rect_xh = longint'($signed(cfg_data));
          plrs_pkg::REG_Y_HIGH:  rect_yh = longint'($signed(cfg_data));
          plrs_pkg::REG_SPACING: spacing = longint'(cfg_data[30:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_sweep(in_angle);
      if (out_valid && out_ready) begin
        if (expected_segments.size() == 0) begin
          report_mismatch("unexpected segment, pending count", 1, 0);
        end else begin
          s = expected_segments.pop_front();
          if (out_start_x != s.sx) report_mismatch("start_x", out_start_x, s.sx);
          if (out_start_y != s.sy) report_mismatch("start_y", out_start_y, s.sy);
          if (out_end_x != s.ex) report_mismatch("end_x", out_end_x, s.ex);
          if (out_end_y != s.ey) report_mismatch("end_y", out_end_y, s.ey);
          if (out_line_index != s.idx) report_mismatch("line_index", out_line_index, s.idx);
          if (out_last_line != s.last) report_mismatch("last_line", out_last_line, s.last);
          if (out_no_lines != s.none) report_mismatch("no_lines", out_no_lines, s.none);
          if (out_count_capped != s.capped)
            report_mismatch("count_capped", out_count_capped, s.capped);
        end
        segments_seen++;
      end
    end
  end

endmodule

// File: verif/parallel_line_rectangle_sweep_tb.sv
module parallel_line_rectangle_sweep_tb;

  // Half pi in Q1.16 sits just past the largest in-range angle.
  localparam logic signed [17:0] ANGLE_MAX = 18'sd102943;
  localparam logic signed [17:0] ANGLE_MIN = -18'sd102944;
  localparam logic signed [17:0] ANGLE_45  = 18'sd51472;
  localparam longint CYCLE_LIMIT = 10000000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [17:0] in_angle = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_start_x, out_start_y, out_end_x, out_end_y;
  logic [5:0]         out_line_index;
  logic               out_last_line, out_no_lines, out_count_capped;
  logic               cfg_wr_en = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  int     errors, pending, segments_seen;
  int     angles_sent = 0;
  int     rect_settings = 1;
  longint cycles = 0;
  bit     calm = 1'b0;    // when set, neither side inserts gaps

  always #2 clk = ~clk;

  parallel_line_rectangle_sweep i_dut (.*);

  parallel_line_rectangle_sweep_checker i_checker (.*);

  // Abort a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d segments still pending", cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: draw a stall per item, then hold ready until the item leaves.
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      n = calm ? 0 : $urandom_range(0, 7);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_angle(logic signed [17:0] ang);
    int n;
    n = calm ? 0 : $urandom_range(0, 7);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_angle <= ang;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    angles_sent++;
  endtask

  // Drop valid, drain the block, then let any tail work settle.
  task automatic drain_sweeps();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Write all five registers back to back; the block is idle here.
  task automatic load_rectangle(logic [31:0] xl, logic [31:0] yl, logic [31:0] xh,
                                logic [31:0] yh, logic [31:0] sp);
    logic [31:0]         vals[5];
    plrs_pkg::plrs_reg_t regs[5];
    vals = '{xl, yl, xh, yh, sp};
    regs = '{plrs_pkg::REG_X_LOW, plrs_pkg::REG_Y_LOW, plrs_pkg::REG_X_HIGH,
             plrs_pkg::REG_Y_HIGH, plrs_pkg::REG_SPACING};
    drain_sweeps();
    for (int i = 0; i < 5; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    rect_settings++;
  endtask

  function automatic logic signed [17:0] random_angle();
    if ($urandom_range(0, 4) == 0) return 18'($urandom);
    return 18'(int'($urandom_range(0, 205887)) - 102944);
  endfunction

  initial begin
    logic signed [31:0] xl, yl;
    int dx, dy, sp;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset rectangle with fine spacing: every sweep hits the line cap.
    send_angle(18'sd0);
    send_angle(ANGLE_MAX);
    send_angle(ANGLE_MIN);
    send_angle(ANGLE_45);
    send_angle(-ANGLE_45);
    send_angle(18'sd131071);      // saturates to +half pi
    send_angle(18'sh20000);       // saturates to -half pi

    // Zero spacing behaves as one LSB on a tiny rectangle.
    load_rectangle(32'd0, 32'd0, 32'd3, 32'd2, 32'd0);
    send_angle(18'sd1);
    send_angle(-18'sd1);
    send_angle(ANGLE_45);

    // Inverted and degenerate rectangles give an empty sweep.
    load_rectangle(32'd655360, 32'd655360, 32'd0, 32'd0, 32'd65536);
    send_angle(18'sd0);
    send_angle(ANGLE_45);
    send_angle(-ANGLE_45);
    load_rectangle(32'd1000, 32'd1000, 32'd1000, 32'd1000, 32'd65536);
    send_angle(ANGLE_MAX);

    // Full coordinate range with the widest spacing: fallbacks saturate.
    load_rectangle(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_angle(18'sd0);
    send_angle(ANGLE_MAX);
    send_angle(ANGLE_MIN);
    send_angle(ANGLE_45);
    send_angle(-18'sd25736);

    // Random rectangles sized for a handful of lines each; alternate calm phases.
    for (int ph = 0; ph < 7; ph++) begin
      xl = (ph == 6) ? 32'h80000000 : 32'(int'($urandom_range(0, 33554432)) - 16777216);
      yl = 32'(int'($urandom_range(0, 33554432)) - 16777216);
      dx = (ph == 2) ? 0 : $urandom_range(0, 4194304);
      dy = $urandom_range(0, 4194304);
      sp = (dx + dy) / $urandom_range(1, 10) + $urandom_range(0, 3);
      if (ph == 5) sp = sp | 32'h40000000;   // exercise the top spacing bit
      load_rectangle(xl, yl, xl + dx, yl + dy, sp);
      calm = ph[0];
      for (int i = 0; i < 17; i++) begin
        if (i == 8) begin
          // Hold off until every pending segment is out.
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_angle(random_angle());
      end
    end
    calm = 1'b0;

    drain_sweeps();
    repeat (300) @(posedge clk);
    $display("Covered %0d angles over %0d rectangle settings, %0d segments checked",
             angles_sent, rect_settings, segments_seen);
    $display("Included capped sweeps, empty sweeps, zero spacing and saturated edges");
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
